[rtl/tnsr_pkg.sv]
// Package for the text newline/space run encoder.
// Holds the channel item types, the command type between front and back,
// and the byte codes. No dependencies.
package tnsr_pkg;

    // Byte codes
    localparam logic [7:0] MARK_BYTE = 8'h09;
    localparam logic [7:0] CR_BYTE   = 8'h0D;
    localparam logic [7:0] LF_BYTE   = 8'h0A;
    localparam logic [7:0] SP_BYTE   = 8'h20;
    localparam logic [6:0] RUN_MAX   = 7'd127;

    // Command queue sizing
    localparam int CMD_MAX_BYTES   = 3;
    localparam int CMD_QUEUE_DEPTH = 4;
    localparam int CMD_PTR_W       = $clog2(CMD_QUEUE_DEPTH);

    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_last;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       has_byte;
        logic       run_last;
        logic       stream_end;
    } t_out_item;

    // One classified input item: up to three bytes to send, in order
    typedef struct packed {
        logic [1:0]                    n;
        logic [CMD_MAX_BYTES-1:0][7:0] bytes;
        logic                          last;
    } t_cmd;

endpackage

[rtl/tnsr_front.sv]
// Front end of the encoder: accepts input beats, tracks the space run and
// turns each beat into at most one command for the queue.
// Depends on tnsr_pkg.
module tnsr_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  tnsr_pkg::t_in_item i_item,
    output logic              o_stall,
    input  logic              i_cmd_full,
    output logic              o_cmd_valid,
    output tnsr_pkg::t_cmd    o_cmd
);
    import tnsr_pkg::*;

    typedef struct packed {
        logic [1:0] len;
        logic [7:0] b0;
        logic [7:0] b1;
    } t_run_code;

    logic [6:0] r_pending;
    logic [6:0] n_pending;
    logic [6:0] lead_run;
    logic [6:0] tail_run;
    logic [6:0] grown;
    logic       is_cr;
    logic       is_sp;
    logic       has_char;
    logic [7:0] char_byte;
    logic       accept;
    t_run_code  lead;
    t_run_code  tail;
    t_cmd       cmd;

    // Encode a closed run: one space as itself, longer runs as marker + count
    function automatic t_run_code encode_run(input logic [6:0] run);
        t_run_code code;
        code.len = 2'd0;
        code.b0  = SP_BYTE;
        code.b1  = {1'b0, run};
        if (run == 7'd1) begin
            code.len = 2'd1;
        end else if (run != 7'd0) begin
            code.len = 2'd2;
            code.b0  = MARK_BYTE;
        end
        return code;
    endfunction

    // Classify the byte and work out the runs to close
    always_comb begin
        is_cr     = (i_item.in_byte == CR_BYTE);
        is_sp     = (i_item.in_byte == SP_BYTE);
        has_char  = !is_cr && !is_sp;
        char_byte = (i_item.in_byte == LF_BYTE) ? CR_BYTE : i_item.in_byte;
        lead_run  = 7'd0;
        grown     = 7'd0;
        if (is_sp) begin
            if (r_pending == RUN_MAX) begin
                lead_run = RUN_MAX;
                grown    = 7'd1;
            end else begin
                grown    = r_pending + 7'd1;
            end
        end else begin
            lead_run = r_pending;
        end
        tail_run  = i_item.in_last ? grown : 7'd0;
        n_pending = i_item.in_last ? 7'd0 : grown;
        lead      = encode_run(lead_run);
        tail      = encode_run(tail_run);
    end

    // Pack lead run, character and tail run into one command
    always_comb begin
        cmd.bytes = '0;
        cmd.n     = 2'd0;
        cmd.last  = i_item.in_last;
        if (lead.len != 2'd0) begin
            cmd.bytes[0] = lead.b0;
            cmd.n        = 2'd1;
        end
        if (lead.len == 2'd2) begin
            cmd.bytes[1] = lead.b1;
            cmd.n        = 2'd2;
        end
        if (has_char && cmd.n != 2'd3) begin
            cmd.bytes[cmd.n] = char_byte;
            cmd.n            = cmd.n + 2'd1;
        end
        if (tail.len != 2'd0 && cmd.n != 2'd3) begin
            cmd.bytes[cmd.n] = tail.b0;
            cmd.n            = cmd.n + 2'd1;
        end
        if (tail.len == 2'd2 && cmd.n != 2'd3) begin
            cmd.bytes[cmd.n] = tail.b1;
            cmd.n            = cmd.n + 2'd1;
        end
    end

    assign o_stall     = i_cmd_full;
    assign accept      = i_valid && !i_cmd_full;
    // Drop commands that send nothing and do not end the stream
    assign o_cmd_valid = accept && (cmd.n != 2'd0 || cmd.last);
    assign o_cmd       = cmd;

    // Advance the run count on every accepted beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= 7'd0;
        end else if (accept) begin
            r_pending <= n_pending;
        end
    end

endmodule

[rtl/tnsr_cmd_queue.sv]
// Short command queue between the front and back ends.
// Depends on tnsr_pkg.
module tnsr_cmd_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  tnsr_pkg::t_cmd i_cmd,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_head_valid,
    output tnsr_pkg::t_cmd o_head
);
    import tnsr_pkg::*;

    t_cmd                 r_mem [CMD_QUEUE_DEPTH];
    logic [CMD_PTR_W-1:0] r_wr_ptr;
    logic [CMD_PTR_W-1:0] r_rd_ptr;
    logic [CMD_PTR_W:0]   r_count;

    assign o_full       = (r_count == (CMD_PTR_W+1)'(CMD_QUEUE_DEPTH));
    assign o_head_valid = (r_count != '0);
    assign o_head       = r_mem[r_rd_ptr];

    // Write the entry at the tail
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

[rtl/tnsr_back.sv]
// Back end of the encoder: walks the head command one byte per cycle, while
// the output is not stalled, into the output register. Depends on tnsr_pkg.
module tnsr_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_head_valid,
    input  tnsr_pkg::t_cmd    i_head,
    output logic              o_pop,
    output logic              o_out_valid,
    output tnsr_pkg::t_out_item o_out_item,
    input  logic              i_out_stall
);
    import tnsr_pkg::*;

    logic      [1:0] r_idx;
    logic            r_out_valid;
    t_out_item       r_out_item;
    logic            load;
    logic            beat_last;
    t_out_item       beat;

    // Build the beat at the current byte index of the head command
    always_comb begin
        load            = !r_out_valid || !i_out_stall;
        beat_last       = (i_head.n == 2'd0) || (r_idx == i_head.n - 2'd1);
        beat.out_byte   = (i_head.n == 2'd0) ? 8'd0 : i_head.bytes[r_idx];
        beat.has_byte   = (i_head.n != 2'd0);
        beat.run_last   = beat_last;
        beat.stream_end = beat_last && i_head.last;
    end

    assign o_pop       = load && i_head_valid && beat_last;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    // Hold the output beat while stalled, otherwise load the next one
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_idx       <= 2'd0;
        end else if (load) begin
            r_out_valid <= i_head_valid;
            if (i_head_valid) begin
                r_idx <= beat_last ? 2'd0 : r_idx + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load && i_head_valid) begin
            r_out_item <= beat;
        end
    end

    // Stream end always closes the beats of its input
    a_end_is_run_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_item.stream_end |-> r_out_item.run_last)
        else $error("stream end without run last");

    // The empty beat appears only as the end of the stream
    a_empty_is_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_out_item.has_byte |-> r_out_item.stream_end)
        else $error("empty beat not at stream end");

    // Mid-command beats step the byte index by one
    a_idx_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load && i_head_valid && !beat_last |=> r_idx == $past(r_idx) + 2'd1)
        else $error("byte index did not advance");

    // Never pop an empty queue
    a_pop_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |-> i_head_valid)
        else $error("pop without head");

endmodule

[rtl/text_newline_space_run_encoder.sv]
// Top level of the text newline/space run encoder.
// Depends on tnsr_pkg, tnsr_front, tnsr_cmd_queue and tnsr_back.
//
//  channel | valid        | stall        | payload
//  --------+--------------+--------------+---------------------------
//  input   | i_in_valid   | o_in_stall   | i_in_item  (t_in_item)
//  output  | o_out_valid  | i_out_stall  | o_out_item (t_out_item)
//
// Each accepted input beat has its command, if any, queued; the back end
// then sends one output beat per cycle while i_out_stall is low, so an
// input item that yields k bytes (k = 1..3, or the single empty end beat)
// gives k output beats. Items yielding at most one beat sustain one item
// per cycle while i_out_stall is low. A four-entry command queue lets the
// front run ahead; o_in_stall rises only when it is full. Reset is
// synchronous and clears the run count, the queue and the output valid.
module text_newline_space_run_encoder (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  tnsr_pkg::t_in_item  i_in_item,
    output logic                o_in_stall,
    output logic                o_out_valid,
    output tnsr_pkg::t_out_item o_out_item,
    input  logic                i_out_stall
);
    import tnsr_pkg::*;

    logic cmd_valid;
    logic cmd_full;
    t_cmd cmd;
    logic head_valid;
    t_cmd head;
    logic pop;

    tnsr_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_in_valid),
        .i_item      (i_in_item),
        .o_stall     (o_in_stall),
        .i_cmd_full  (cmd_full),
        .o_cmd_valid (cmd_valid),
        .o_cmd       (cmd)
    );

    tnsr_cmd_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (cmd_valid),
        .i_cmd        (cmd),
        .o_full       (cmd_full),
        .i_pop        (pop),
        .o_head_valid (head_valid),
        .o_head       (head)
    );

    tnsr_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head_valid (head_valid),
        .i_head       (head),
        .o_pop        (pop),
        .o_out_valid  (o_out_valid),
        .o_out_item   (o_out_item),
        .i_out_stall  (i_out_stall)
    );

endmodule
